// File: rtl/zmd_pkg.sv
// Shared types, constants and the microcode program of the Zobrist move delta unit.
// Used by zobrist_move_delta; depends on nothing else.

package zmd_pkg;

   localparam int KEY_WIDTH   = 64;
   localparam int TABLE_DEPTH = 782;
   localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int PC_WIDTH    = 4;

   // Key table layout.
   localparam logic [ADDR_WIDTH-1:0] COLOUR_STRIDE = ADDR_WIDTH'(384);
   localparam logic [ADDR_WIDTH-1:0] EP_BASE       = ADDR_WIDTH'(768);
   localparam logic [ADDR_WIDTH-1:0] SIDE_BASE     = ADDR_WIDTH'(776);
   localparam logic [ADDR_WIDTH-1:0] CASTLE_BASE   = ADDR_WIDTH'(778);
   localparam logic [ADDR_WIDTH-1:0] TABLE_LIMIT   = ADDR_WIDTH'(TABLE_DEPTH);

   // Request codes.
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_MOVE = 2'd1;
   localparam logic [1:0] REQ_NULL = 2'd2;

   // Move flag bit positions.
   localparam int FLAG_DOUBLE    = 0;
   localparam int FLAG_CAPTURE   = 1;
   localparam int FLAG_EP        = 2;
   localparam int FLAG_CASTLE    = 3;
   localparam int FLAG_QUEENSIDE = 4;
   localparam int FLAG_PROMO     = 5;

   // Piece codes.
   localparam logic [2:0] PIECE_PAWN = 3'd0;
   localparam logic [2:0] PIECE_ROOK = 3'd3;
   localparam logic [2:0] PIECE_KING = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Which key a microcode step reads.
   typedef enum logic [3:0] {
      SRC_FROM,
      SRC_TO,
      SRC_NEW_EP,
      SRC_CASTLE_RIGHT,
      SRC_CAPTURE,
      SRC_ROOK_FROM,
      SRC_ROOK_TO,
      SRC_PROMO_PAWN,
      SRC_PROMO_NEW,
      SRC_OLD_EP,
      SRC_SIDE
   } src_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_NO_CASTLE,
      JMP_NO_PROMO
   } jump_type;

   typedef struct packed {
      src_type               src;
      logic [1:0]            arg;
      jump_type              jump;
      logic [PC_WIDTH-1:0]   target;
      logic                  last;
   } uword_type;

   // Program entry points and jump targets.
   localparam logic [PC_WIDTH-1:0] MOVE_ENTRY = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] STEP_PROMO = PC_WIDTH'(10);
   localparam logic [PC_WIDTH-1:0] NULL_ENTRY = PC_WIDTH'(12);
   localparam logic [PC_WIDTH-1:0] LAST_STEP  = PC_WIDTH'(14);

   function automatic uword_type make_word(input src_type src, input logic [1:0] arg,
                                           input jump_type jump,
                                           input logic [PC_WIDTH-1:0] target,
                                           input logic last);
      uword_type w;
      w.src    = src;
      w.arg    = arg;
      w.jump   = jump;
      w.target = target;
      w.last   = last;
      return w;
   endfunction

   // Microcode ROM. The move program runs from step 0; the null-move program
   // shares the tail that starts at the old en-passant key.
   function automatic uword_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      uword_type w;
      case (pc)
         4'd0:    w = make_word(SRC_FROM,         2'd0, JMP_NONE,      '0,         1'b0);
         4'd1:    w = make_word(SRC_TO,           2'd0, JMP_NONE,      '0,         1'b0);
         4'd2:    w = make_word(SRC_NEW_EP,       2'd0, JMP_NONE,      '0,         1'b0);
         4'd3:    w = make_word(SRC_CASTLE_RIGHT, 2'd0, JMP_NONE,      '0,         1'b0);
         4'd4:    w = make_word(SRC_CASTLE_RIGHT, 2'd1, JMP_NONE,      '0,         1'b0);
         4'd5:    w = make_word(SRC_CASTLE_RIGHT, 2'd2, JMP_NONE,      '0,         1'b0);
         4'd6:    w = make_word(SRC_CASTLE_RIGHT, 2'd3, JMP_NONE,      '0,         1'b0);
         4'd7:    w = make_word(SRC_CAPTURE,      2'd0, JMP_NO_CASTLE, STEP_PROMO, 1'b0);
         4'd8:    w = make_word(SRC_ROOK_FROM,    2'd0, JMP_NONE,      '0,         1'b0);
         4'd9:    w = make_word(SRC_ROOK_TO,      2'd0, JMP_NO_PROMO,  NULL_ENTRY, 1'b0);
         4'd10:   w = make_word(SRC_PROMO_PAWN,   2'd0, JMP_NONE,      '0,         1'b0);
         4'd11:   w = make_word(SRC_PROMO_NEW,    2'd0, JMP_NONE,      '0,         1'b0);
         4'd12:   w = make_word(SRC_OLD_EP,       2'd0, JMP_NONE,      '0,         1'b0);
         4'd13:   w = make_word(SRC_SIDE,         2'd0, JMP_NONE,      '0,         1'b0);
         4'd14:   w = make_word(SRC_SIDE,         2'd1, JMP_NONE,      '0,         1'b1);
         default: w = make_word(SRC_SIDE,         2'd0, JMP_NONE,      '0,         1'b1);
      endcase
      return w;
   endfunction

   // Table slot of a piece key; the caller checks that the piece code is valid.
   function automatic logic [ADDR_WIDTH-1:0] piece_addr(input logic colour,
                                                        input logic [2:0] piece,
                                                        input logic [5:0] square);
      logic [ADDR_WIDTH-1:0] base;
      base = colour ? COLOUR_STRIDE : '0;
      return ADDR_WIDTH'({piece, square}) + base;
   endfunction

   // Rook origin (dest = 0) or destination (dest = 1) square for a castle.
   function automatic logic [5:0] rook_square(input logic colour, input logic queenside,
                                              input logic dest);
      logic [2:0] file;
      logic [2:0] rank;
      if (dest) begin
         file = queenside ? 3'd3 : 3'd5;
      end else begin
         file = queenside ? 3'd0 : 3'd7;
      end
      rank = colour ? 3'd7 : 3'd0;
      return {rank, file};
   endfunction

endpackage

// File: rtl/zmd_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.

module zmd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 782
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         storage_ff[addr] <= wdata;
      end
      rdata_ff <= storage_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/zobrist_move_delta.sv
// Top level of the Zobrist move delta unit: key table, microcode sequencer, accumulator.
// Depends on zmd_pkg and zmd_ram.

// The unit holds a 782-entry table of random keys and returns the XOR
// difference that one chess move makes to a position hash. A load item
// (req_type 0) writes one key and returns no result; a load to a slot above
// 781 and a request of type 3 are dropped. A move item (req_type 1) or a
// null-move item (req_type 2) starts a short microcode program that reads one
// key per cycle from the single-port key table and XORs the enabled ones into
// an accumulator. That single read port sets the pace: a move runs 13 steps,
// or 15 when it both castles and promotes, and a null move runs 3 steps. The
// DRAIN state then lets the last key arrive and the FINISH state moves the
// sum into the output register; only then does the unit take the next item.
// The result sits in its own register, so the unit takes the next item while
// an earlier result still waits on rsp_ready; it holds a new result back only
// when the old one has not been taken. Keys read before they have been loaded
// give an undefined result. The result is hash_delta, zero-extended from the
// key width.

module zobrist_move_delta (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [zmd_pkg::ADDR_WIDTH-1:0] req_entry_index,
   input  logic [63:0]                   req_entry_value,
   input  logic                          req_side,
   input  logic [2:0]                    req_moving_piece,
   input  logic [5:0]                    req_origin_square,
   input  logic [5:0]                    req_target_square,
   input  logic [2:0]                    req_captured_piece,
   input  logic [2:0]                    req_promoted_piece,
   input  logic [5:0]                    req_move_flags,
   input  logic [3:0]                    req_last_ep_file,
   input  logic [3:0]                    req_castling_change,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [63:0]                   rsp_hash_delta
);

   import zmd_pkg::*;

   // Sequencer state.
   state_type             state_ff, state_in;
   logic [PC_WIDTH-1:0]   pc_ff, pc_in;
   uword_type             uword;
   logic                  jump_taken;

   // Item captured at acceptance.
   logic                  side_ff;
   logic [2:0]            piece_ff;
   logic [5:0]            from_ff;
   logic [5:0]            to_ff;
   logic [2:0]            capt_ff;
   logic [2:0]            promo_ff;
   logic [5:0]            flags_ff;
   logic [3:0]            last_ep_ff;
   logic [3:0]            castling_ff;

   // Key read and accumulation.
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic                  rd_en;
   logic                  acc_en_ff, acc_en_in;
   logic [KEY_WIDTH-1:0]  acc_ff, acc_in;
   logic [KEY_WIDTH-1:0]  key_rdata;
   logic [ADDR_WIDTH-1:0] ram_addr;
   logic                  ram_we;

   // Control decode.
   logic                  req_accept;
   logic                  start_item;
   logic                  load_rsp;
   logic                  running;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]  rsp_delta_ff;

   assign req_accept = req_valid && req_ready;
   assign uword      = ucode_rom(pc_ff);

   always_comb begin
      start_item = 1'b0;
      if (req_accept) begin
         start_item = req_type inside {REQ_MOVE, REQ_NULL};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_item) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (uword.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      running   = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            running = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // Conditional jumps skip the rook or promotion steps when they cannot apply.
   always_comb begin
      case (uword.jump)
         JMP_NO_CASTLE: jump_taken = !flags_ff[FLAG_CASTLE];
         JMP_NO_PROMO:  jump_taken = !flags_ff[FLAG_PROMO];
         default:       jump_taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (start_item) begin
         pc_in = (req_type == REQ_NULL) ? NULL_ENTRY : MOVE_ENTRY;
      end else if (running && !uword.last) begin
         pc_in = jump_taken ? uword.target : pc_ff + PC_WIDTH'(1);
      end
   end

   // Key address and whether the key takes part, from the current step.
   always_comb begin
      rd_addr = '0;
      rd_en   = 1'b0;
      case (uword.src)
         SRC_FROM: begin
            rd_addr = piece_addr(side_ff, piece_ff, from_ff);
            rd_en   = piece_ff <= PIECE_KING;
         end
         SRC_TO: begin
            rd_addr = piece_addr(side_ff, piece_ff, to_ff);
            rd_en   = piece_ff <= PIECE_KING;
         end
         SRC_NEW_EP: begin
            rd_addr = EP_BASE + ADDR_WIDTH'(from_ff[2:0]);
            rd_en   = flags_ff[FLAG_DOUBLE];
         end
         SRC_CASTLE_RIGHT: begin
            rd_addr = CASTLE_BASE + ADDR_WIDTH'(uword.arg);
            rd_en   = castling_ff[uword.arg];
         end
         SRC_CAPTURE: begin
            // An en-passant capture removes the pawn beside the origin.
            if (flags_ff[FLAG_EP]) begin
               rd_addr = piece_addr(!side_ff, PIECE_PAWN, {from_ff[5:3], to_ff[2:0]});
               rd_en   = 1'b1;
            end else begin
               rd_addr = piece_addr(!side_ff, capt_ff, to_ff);
               rd_en   = flags_ff[FLAG_CAPTURE] && (capt_ff <= PIECE_KING);
            end
         end
         SRC_ROOK_FROM: begin
            rd_addr = piece_addr(side_ff, PIECE_ROOK,
                                 rook_square(side_ff, flags_ff[FLAG_QUEENSIDE], 1'b0));
            rd_en   = flags_ff[FLAG_CASTLE];
         end
         SRC_ROOK_TO: begin
            rd_addr = piece_addr(side_ff, PIECE_ROOK,
                                 rook_square(side_ff, flags_ff[FLAG_QUEENSIDE], 1'b1));
            rd_en   = flags_ff[FLAG_CASTLE];
         end
         SRC_PROMO_PAWN: begin
            rd_addr = piece_addr(side_ff, PIECE_PAWN, to_ff);
            rd_en   = flags_ff[FLAG_PROMO];
         end
         SRC_PROMO_NEW: begin
            rd_addr = piece_addr(side_ff, promo_ff, to_ff);
            rd_en   = flags_ff[FLAG_PROMO] && (promo_ff <= PIECE_KING);
         end
         SRC_OLD_EP: begin
            rd_addr = EP_BASE + ADDR_WIDTH'(last_ep_ff[2:0]);
            rd_en   = !last_ep_ff[3];
         end
         SRC_SIDE: begin
            rd_addr = SIDE_BASE + ADDR_WIDTH'(uword.arg);
            rd_en   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Loads write only while idle; the sequencer owns the port otherwise.
   assign ram_we   = req_accept && (req_type == REQ_LOAD) && (req_entry_index < TABLE_LIMIT);
   assign ram_addr = running ? rd_addr : req_entry_index;

   zmd_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_key_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_entry_value[KEY_WIDTH-1:0]),
      .rdata (key_rdata)
   );

   // The key read in one step arrives in the next cycle.
   assign acc_en_in = running && rd_en;

   always_comb begin
      acc_in = acc_ff;
      if (start_item) begin
         acc_in = '0;
      end else if (acc_en_ff) begin
         acc_in = acc_ff ^ key_rdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= MOVE_ENTRY;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_en_ff    <= acc_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (load_rsp) begin
         rsp_delta_ff <= acc_ff;
      end
      if (start_item) begin
         side_ff     <= req_side;
         piece_ff    <= req_moving_piece;
         from_ff     <= req_origin_square;
         to_ff       <= req_target_square;
         capt_ff     <= req_captured_piece;
         promo_ff    <= req_promoted_piece;
         flags_ff    <= req_move_flags;
         last_ep_ff  <= req_last_ep_file;
         castling_ff <= req_castling_change;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_delta = 64'(rsp_delta_ff);

   // The step counter never runs past the end of the program.
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= LAST_STEP))
      else $error("step counter left the microcode program");

   // A move or null-move item starts the program with a cleared sum.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start_item |=> (state_ff == ST_RUN) && (acc_ff == '0))
      else $error("item start did not enter the program with a cleared sum");

   // Keys are summed only in the cycle after a running step issued them.
   a_acc_after_run: assert property (@(posedge clock) disable iff (reset)
      acc_en_ff |-> ($past(state_ff) == ST_RUN))
      else $error("key summed outside the program");

endmodule
